/* sv/hrsp_pkg.sv */
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, limits and character constants for the HTTP request stream
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrsp_pkg;

   // Saturation limits for the entry counters
   localparam int unsigned PARAM_LIMIT  = 16;
   localparam int unsigned HEADER_LIMIT = 32;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CLASS_W  = 4;
   localparam int unsigned METHOD_W = 3;
   localparam int unsigned PARAM_W  = 5;
   localparam int unsigned HEADER_W = 6;
   localparam int unsigned POS_W    = 3;

   // Characters the parser reacts to
   localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
   localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
   localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
   localparam logic [BYTE_W-1:0] CH_O     = 8'h4f;
   localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CH_U     = 8'h55;
   localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3f;
   localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

   // Per-byte classification tag
   typedef enum logic [CLASS_W-1:0] {
      CLS_METHOD    = 4'd0,
      CLS_PATH      = 4'd1,
      CLS_QUESTION  = 4'd2,
      CLS_PARAM     = 4'd3,
      CLS_AMPERSAND = 4'd4,
      CLS_TAIL      = 4'd5,
      CLS_BREAK     = 4'd6,
      CLS_HEADER    = 4'd7,
      CLS_IGNORED   = 4'd8
   } byte_class_type;

   // Method outcome
   typedef enum logic [METHOD_W-1:0] {
      MTH_NONE  = 3'd0,
      MTH_GET   = 3'd1,
      MTH_POST  = 3'd2,
      MTH_PUT   = 3'd3,
      MTH_ERROR = 3'd4
   } method_type;

   // Parser phase, one-hot
   typedef enum logic [5:0] {
      PH_METHOD     = 6'b000001,
      PH_PATH       = 6'b000010,
      PH_TAIL       = 6'b000100,
      PH_LINE_START = 6'b001000,
      PH_HEADERS    = 6'b010000,
      PH_ERROR      = 6'b100000
   } phase_type;

   // Expected character of a method token at a given position (0 = none)
   function automatic logic [BYTE_W-1:0] method_char(method_type m,
                                                     logic [POS_W-1:0] pos);
      logic [BYTE_W-1:0] c;
      c = CH_NUL;
      unique case (m)
         MTH_GET: begin
            case (pos)
               3'd0:    c = CH_G;
               3'd1:    c = CH_E;
               3'd2:    c = CH_T;
               3'd3:    c = CH_SPACE;
               default: c = CH_NUL;
            endcase
         end
         MTH_POST: begin
            case (pos)
               3'd0:    c = CH_P;
               3'd1:    c = CH_O;
               3'd2:    c = CH_S;
               3'd3:    c = CH_T;
               3'd4:    c = CH_SPACE;
               default: c = CH_NUL;
            endcase
         end
         MTH_PUT: begin
            case (pos)
               3'd0:    c = CH_P;
               3'd1:    c = CH_U;
               3'd2:    c = CH_T;
               3'd3:    c = CH_SPACE;
               default: c = CH_NUL;
            endcase
         end
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   // Token length including the closing space
   function automatic logic [POS_W-1:0] method_len(method_type m);
      logic [POS_W-1:0] n;
      unique case (m)
         MTH_GET:  n = 3'd4;
         MTH_POST: n = 3'd5;
         MTH_PUT:  n = 3'd4;
         default:  n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

/* sv/http_request_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// http_request_stream_parser_core
// Byte-at-a-time HTTP request line and header parser with per-byte tagging.
// ----------------------------------------------------------------------------
// One beat in carries one request byte; one beat out follows for every byte,
// tagged with its class, the method outcome, the parameter and header counts
// and an overflow flag. A zero byte closes the request, reports the final
// outcome and rearms the parser. The block takes one byte per clock unless
// the output stalls: the parse state update and the result tag are computed
// combinationally into the output register, so each tag follows next cycle;
// the input is ready whenever it is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_stream_parser_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request byte channel
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [hrsp_pkg::BYTE_W-1:0]   req_data_byte,
   // tagged byte channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [hrsp_pkg::CLASS_W-1:0]  rsp_byte_class,
   output      logic [hrsp_pkg::BYTE_W-1:0]   rsp_byte_echo,
   output      logic [hrsp_pkg::METHOD_W-1:0] rsp_method_code,
   output      logic [hrsp_pkg::PARAM_W-1:0]  rsp_param_number,
   output      logic [hrsp_pkg::HEADER_W-1:0] rsp_header_number,
   output      logic                          rsp_starts_entry,
   output      logic                          rsp_count_overflow,
   output      logic                          rsp_request_done
);

   localparam logic [hrsp_pkg::PARAM_W-1:0] PARAM_MAX =
      hrsp_pkg::PARAM_W'(hrsp_pkg::PARAM_LIMIT);
   localparam logic [hrsp_pkg::HEADER_W-1:0] HEADER_MAX =
      hrsp_pkg::HEADER_W'(hrsp_pkg::HEADER_LIMIT);

   // parse state
   hrsp_pkg::phase_type               phase_ff, phase_in;
   logic [hrsp_pkg::POS_W-1:0]        match_pos_ff, match_pos_in;
   hrsp_pkg::method_type              method_ff, method_in;
   logic [hrsp_pkg::PARAM_W-1:0]      param_cnt_ff, param_cnt_in;
   logic [hrsp_pkg::HEADER_W-1:0]     header_cnt_ff, header_cnt_in;
   logic                              after_quest_ff, after_quest_in;
   logic                              after_break_ff, after_break_in;
   logic                              overflow_ff, overflow_in;

   // result register
   logic                              rsp_valid_ff;
   hrsp_pkg::byte_class_type          class_ff, class_in;
   logic [hrsp_pkg::BYTE_W-1:0]       echo_ff;
   hrsp_pkg::method_type              code_ff, code_in;
   logic [hrsp_pkg::PARAM_W-1:0]      param_num_ff;
   logic [hrsp_pkg::HEADER_W-1:0]     header_num_ff;
   logic                              start_ff, start_in;
   logic                              ovf_out_ff;
   logic                              done_ff, done_in;

   logic                              accept;
   logic [hrsp_pkg::BYTE_W-1:0]       b;
   hrsp_pkg::method_type              seen;
   logic [hrsp_pkg::PARAM_W-1:0]      pcnt;
   hrsp_pkg::phase_type               phase_post;
   hrsp_pkg::method_type              method_post;
   logic [hrsp_pkg::POS_W-1:0]        pos_post;
   logic [hrsp_pkg::POS_W-1:0]        pos_inc;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign b         = req_data_byte;
   assign pos_inc   = match_pos_ff + 3'd1;

   // next parse state and the tag of the current byte
   always_comb begin
      class_in       = hrsp_pkg::CLS_IGNORED;
      start_in       = 1'b0;
      done_in        = 1'b0;
      seen           = method_ff;
      pcnt           = param_cnt_ff;
      phase_post     = phase_ff;
      method_post    = method_ff;
      pos_post       = match_pos_ff;
      param_cnt_in   = param_cnt_ff;
      header_cnt_in  = header_cnt_ff;
      after_quest_in = after_quest_ff;
      after_break_in = after_break_ff;
      overflow_in    = overflow_ff;

      if (b == hrsp_pkg::CH_NUL) begin
         done_in = 1'b1;
         if (phase_ff == hrsp_pkg::PH_METHOD || phase_ff == hrsp_pkg::PH_PATH) begin
            method_post = hrsp_pkg::MTH_ERROR;
         end
      end else begin
         unique case (phase_ff)
            hrsp_pkg::PH_METHOD: begin
               class_in = hrsp_pkg::CLS_METHOD;
               if (match_pos_ff == 3'd0) begin
                  seen = (b == hrsp_pkg::CH_G) ? hrsp_pkg::MTH_GET :
                         (b == hrsp_pkg::CH_P) ? hrsp_pkg::MTH_POST :
                                                 hrsp_pkg::MTH_ERROR;
               end else if (match_pos_ff == 3'd1 && method_ff == hrsp_pkg::MTH_POST &&
                            b == hrsp_pkg::CH_U) begin
                  seen = hrsp_pkg::MTH_PUT;
               end
               if (seen != hrsp_pkg::MTH_ERROR && seen != hrsp_pkg::MTH_NONE &&
                   match_pos_ff < 3'd5 &&
                   hrsp_pkg::method_char(seen, match_pos_ff) == b) begin
                  method_post = seen;
                  pos_post    = pos_inc;
                  if (pos_inc >= hrsp_pkg::method_len(seen)) begin
                     phase_post = hrsp_pkg::PH_PATH;
                  end
               end else begin
                  method_post = hrsp_pkg::MTH_ERROR;
                  phase_post  = hrsp_pkg::PH_ERROR;
               end
            end
            hrsp_pkg::PH_PATH: begin
               if (b == hrsp_pkg::CH_SPACE || b == hrsp_pkg::CH_LF ||
                   b == hrsp_pkg::CH_CR) begin
                  class_in   = hrsp_pkg::CLS_TAIL;
                  phase_post = hrsp_pkg::PH_TAIL;
               end else if (!after_quest_ff) begin
                  if (b == hrsp_pkg::CH_QUEST) begin
                     class_in       = hrsp_pkg::CLS_QUESTION;
                     after_quest_in = 1'b1;
                  end else begin
                     class_in = hrsp_pkg::CLS_PATH;
                  end
               end else begin
                  // first query byte opens parameter 1, each '&' one more
                  class_in = hrsp_pkg::CLS_PARAM;
                  if (param_cnt_ff == '0) begin
                     pcnt     = hrsp_pkg::PARAM_W'(1);
                     start_in = 1'b1;
                  end
                  if (b == hrsp_pkg::CH_AMP) begin
                     class_in = hrsp_pkg::CLS_AMPERSAND;
                     start_in = 1'b1;
                     if (pcnt < PARAM_MAX) begin
                        pcnt = pcnt + 1'b1;
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  param_cnt_in = pcnt;
               end
            end
            hrsp_pkg::PH_TAIL: begin
               if (b == hrsp_pkg::CH_LF) begin
                  class_in       = hrsp_pkg::CLS_BREAK;
                  phase_post     = hrsp_pkg::PH_LINE_START;
                  after_break_in = 1'b1;
               end else begin
                  class_in = hrsp_pkg::CLS_TAIL;
               end
            end
            hrsp_pkg::PH_LINE_START, hrsp_pkg::PH_HEADERS: begin
               if (phase_ff == hrsp_pkg::PH_LINE_START && b == hrsp_pkg::CH_CR) begin
                  // skipped CR right after a line break
                  class_in   = hrsp_pkg::CLS_IGNORED;
                  phase_post = hrsp_pkg::PH_HEADERS;
               end else begin
                  phase_post = hrsp_pkg::PH_HEADERS;
                  if (after_break_ff) begin
                     start_in       = 1'b1;
                     after_break_in = 1'b0;
                     if (header_cnt_ff < HEADER_MAX) begin
                        header_cnt_in = header_cnt_ff + 1'b1;
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  if (b == hrsp_pkg::CH_LF) begin
                     class_in       = hrsp_pkg::CLS_BREAK;
                     phase_post     = hrsp_pkg::PH_LINE_START;
                     after_break_in = 1'b1;
                  end else begin
                     class_in = hrsp_pkg::CLS_HEADER;
                  end
               end
            end
            default: begin
               class_in = hrsp_pkg::CLS_IGNORED;
            end
         endcase
      end

      // method reads undecided until the token is complete
      code_in = method_post;
      if (phase_post == hrsp_pkg::PH_METHOD && method_post != hrsp_pkg::MTH_ERROR &&
          !done_in) begin
         code_in = hrsp_pkg::MTH_NONE;
      end

      phase_in     = phase_post;
      method_in    = method_post;
      match_pos_in = pos_post;
   end

   // parse state registers; a zero byte rearms everything
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= hrsp_pkg::PH_METHOD;
         match_pos_ff   <= '0;
         method_ff      <= hrsp_pkg::MTH_NONE;
         param_cnt_ff   <= '0;
         header_cnt_ff  <= '0;
         after_quest_ff <= 1'b0;
         after_break_ff <= 1'b0;
         overflow_ff    <= 1'b0;
      end else if (accept) begin
         if (done_in) begin
            phase_ff       <= hrsp_pkg::PH_METHOD;
            match_pos_ff   <= '0;
            method_ff      <= hrsp_pkg::MTH_NONE;
            param_cnt_ff   <= '0;
            header_cnt_ff  <= '0;
            after_quest_ff <= 1'b0;
            after_break_ff <= 1'b0;
            overflow_ff    <= 1'b0;
         end else begin
            phase_ff       <= phase_in;
            match_pos_ff   <= match_pos_in;
            method_ff      <= method_in;
            param_cnt_ff   <= param_cnt_in;
            header_cnt_ff  <= header_cnt_in;
            after_quest_ff <= after_quest_in;
            after_break_ff <= after_break_in;
            overflow_ff    <= overflow_in;
         end
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         class_ff      <= class_in;
         echo_ff       <= b;
         code_ff       <= code_in;
         param_num_ff  <= param_cnt_in;
         header_num_ff <= header_cnt_in;
         start_ff      <= start_in;
         ovf_out_ff    <= overflow_in;
         done_ff       <= done_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_class     = class_ff;
   assign rsp_byte_echo      = echo_ff;
   assign rsp_method_code    = code_ff;
   assign rsp_param_number   = param_num_ff;
   assign rsp_header_number  = header_num_ff;
   assign rsp_starts_entry   = start_ff;
   assign rsp_count_overflow = ovf_out_ff;
   assign rsp_request_done   = done_ff;

   // a zero byte leaves the parser rearmed
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data_byte == hrsp_pkg::CH_NUL) |=>
         (phase_ff == hrsp_pkg::PH_METHOD && param_cnt_ff == '0 &&
          header_cnt_ff == '0 && !overflow_ff))
      else $error("parser not rearmed after request end");

   // done beats carry the zero byte and begin no entry
   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_request_done) |->
         (rsp_byte_echo == hrsp_pkg::CH_NUL && !rsp_starts_entry &&
          rsp_byte_class == hrsp_pkg::CLS_IGNORED))
      else $error("bad request end beat");

   // only parameter, ampersand, header or break bytes open an entry
   a_entry_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_starts_entry) |->
         (rsp_byte_class == hrsp_pkg::CLS_PARAM ||
          rsp_byte_class == hrsp_pkg::CLS_AMPERSAND ||
          rsp_byte_class == hrsp_pkg::CLS_HEADER ||
          rsp_byte_class == hrsp_pkg::CLS_BREAK))
      else $error("entry start on wrong byte class");

   // overflow only once a counter sits at its limit
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (param_cnt_ff == PARAM_MAX || header_cnt_ff == HEADER_MAX))
      else $error("overflow without saturated count");

   // a held result is not overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !accept)
      else $error("byte accepted over a stalled result");

endmodule

`default_nettype wire
